// ===== design/lti4_pkg.sv =====
// ----------------------------------------------------------------------------
// lti4_pkg
// Shared widths, types, status codes and saturating helpers for the 4x4
// lower triangular inverse core.
// ----------------------------------------------------------------------------
package lti4_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Internal values are clamped to +-(2^MAG_W - 1).
  localparam int MAG_W  = 60;
  localparam int IW     = MAG_W + 1;
  localparam int HALF_W = MAG_W / 2;
  localparam int HI_W   = MAG_W - HALF_W;
  localparam int PROD_W = 2 * MAG_W;

  // Numerator of the reciprocal: 2^(2*FRAC_BITS) plus half the divisor.
  localparam int NUM_W = ((2 * FRAC_BITS > DATA_WIDTH - 2) ? 2 * FRAC_BITS : DATA_WIDTH - 2) + 1;
  localparam int CMP_W = (NUM_W > MAG_W) ? NUM_W : MAG_W;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [IW-1:0]         q_t;
  typedef logic [MAG_W-1:0]             mag_t;

  localparam mag_t  Q_LIMIT = {MAG_W{1'b1}};
  localparam data_t OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam data_t ONE_VAL = (FRAC_BITS < DATA_WIDTH - 1) ?
                              data_t'(longint'(1) << FRAC_BITS) : OUT_MAX;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    q_t   v;
    logic sat;
  } qs_t;

  typedef struct packed {
    data_t v;
    logic  sat;
  } ds_t;

  function automatic qs_t add_clamp(q_t a, q_t b);
    logic signed [IW:0] s;
    qs_t r;
    s = (IW+1)'(a) + (IW+1)'(b);
    if (s > $signed({2'b00, Q_LIMIT})) begin
      r.v   = $signed({1'b0, Q_LIMIT});
      r.sat = 1'b1;
    end else if (s < -$signed({2'b00, Q_LIMIT})) begin
      r.v   = -$signed({1'b0, Q_LIMIT});
      r.sat = 1'b1;
    end else begin
      r.v   = s[IW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic ds_t sat_out(q_t v);
    ds_t r;
    if (v > q_t'(OUT_MAX)) begin
      r.v   = OUT_MAX;
      r.sat = 1'b1;
    end else if (v < q_t'(OUT_MIN)) begin
      r.v   = OUT_MIN;
      r.sat = 1'b1;
    end else begin
      r.v   = v[DATA_WIDTH-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== design/lower_triangular_inverse_4x4_core.sv =====
// ----------------------------------------------------------------------------
// lower_triangular_inverse_4x4_core: inverse of a 4x4 lower triangular matrix
// The pipeline depth is set by the bit-per-stage reciprocal pipeline and by
// four chained multipliers.
// Throughput: one matrix per cycle; a stall on the output freezes every stage.
// Reset clears the stage valid bits only; no other state is kept.
// ----------------------------------------------------------------------------
module lower_triangular_inverse_4x4_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  lti4_pkg::data_t l_r0c0,
  input  lti4_pkg::data_t l_r1c0,
  input  lti4_pkg::data_t l_r1c1,
  input  lti4_pkg::data_t l_r2c0,
  input  lti4_pkg::data_t l_r2c1,
  input  lti4_pkg::data_t l_r2c2,
  input  lti4_pkg::data_t l_r3c0,
  input  lti4_pkg::data_t l_r3c1,
  input  lti4_pkg::data_t l_r3c2,
  input  lti4_pkg::data_t l_r3c3,
  output logic            out_valid,
  input  logic            out_stall,
  output lti4_pkg::data_t inv_r0c0,
  output lti4_pkg::data_t inv_r1c0,
  output lti4_pkg::data_t inv_r1c1,
  output lti4_pkg::data_t inv_r2c0,
  output lti4_pkg::data_t inv_r2c1,
  output lti4_pkg::data_t inv_r2c2,
  output lti4_pkg::data_t inv_r3c0,
  output lti4_pkg::data_t inv_r3c1,
  output lti4_pkg::data_t inv_r3c2,
  output lti4_pkg::data_t inv_r3c3,
  output logic [1:0]      status
);
  import lti4_pkg::*;

  localparam int TD = NUM_W + 2;
  localparam int TE = TD + 16;
  localparam int TO = TE + 1;

  typedef struct packed {
    logic zero;
    logic sat;
  } flag_t;

  typedef struct packed {
    data_t l10;
    data_t l21;
    data_t l30;
    data_t l31;
    data_t l32;
  } lsel_t;

  typedef struct packed {
    q_t n20;
    q_t n31;
  } nq_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] ua;
    logic [NUM_W-1:0]      num;
    logic [DATA_WIDTH-1:0] rem;
    logic [NUM_W-1:0]      q;
    logic                  neg;
  } dv_t;

  logic [TO:0] vld;
  logic        en;

  data_t l00, l10, l11, l20, l21, l22, l30, l31, l32, l33;
  data_t dg [0:3];
  lsel_t ll [1:TD+8];
  flag_t fl [0:TE];
  logic [TE:0] evt;

  // First level of products, all from the inputs, then the second level.
  q_t   pa, pb, pc, pe, pf, pg;
  logic pa_s, pb_s, pc_s, pe_s, pf_s, pg_s;
  q_t   f30, g31, b32, a32;
  logic f30_s, g31_s, b32_s, a32_s;

  qs_t  n20_c, n31_c, s1_c, s2_c, s3_c;
  nq_t  nl [5:TD+4];
  logic n_sat;
  q_t   s1, s2, b32_9, a32_9, a32_10;
  logic s1_sat, s2_sat, s3_sat;
  q_t   sl [11:TD];

  dv_t  dv_in [0:3];
  dv_t  dv    [0:3][1:NUM_W+1];
  dv_t  dv_nx [0:3][2:NUM_W+1];
  logic [DATA_WIDTH:0] dv_tr [0:3][2:NUM_W+1];
  logic [CMP_W-1:0]    dq    [0:3];
  logic [3:0] dq_sat;
  mag_t dq_mag [0:3];
  q_t   dl [TD:TE][0:3];
  logic [3:0] d_sat;

  q_t   c6a, c6b, c6c, c6d, c3a, c3b, c3c, c7a, c7b, c7c, c1a, c1b, c4a, c4b, c8a, c8b;
  logic c6a_s, c6b_s, c6c_s, c6d_s, c3a_s, c3b_s, c3c_s, c7a_s, c7b_s, c7c_s;
  logic c1a_s, c1b_s, c4a_s, c4b_s, c8a_s, c8b_s;

  q_t    rv [0:9];
  ds_t   os [0:9];
  logic  any_sat;
  data_t ov [0:9];
  status_t st;

  // The whole pipeline advances together unless the output holds a stalled result.
  assign en       = !vld[TO] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TO-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l00 <= l_r0c0; l10 <= l_r1c0; l11 <= l_r1c1; l20 <= l_r2c0; l21 <= l_r2c1;
      l22 <= l_r2c2; l30 <= l_r3c0; l31 <= l_r3c1; l32 <= l_r3c2; l33 <= l_r3c3;
      fl[0].zero <= (l_r0c0 == '0) || (l_r1c1 == '0) || (l_r2c2 == '0) || (l_r3c3 == '0);
      fl[0].sat  <= 1'b0;
      for (int k = 1; k <= TE; k++) begin
        fl[k].zero <= fl[k-1].zero;
        fl[k].sat  <= fl[k-1].sat | evt[k-1];
      end
      ll[1] <= '{l10: l10, l21: l21, l30: l30, l31: l31, l32: l32};
      for (int k = 2; k <= TD + 8; k++) begin
        ll[k] <= ll[k-1];
      end
    end
  end

  // ---------------- products that do not need the reciprocals ----------------
  lti4_mulq u_pa (.clk, .en, .x(q_t'(l10)), .y(q_t'(l21)), .z(pa), .sat(pa_s));
  lti4_mulq u_pb (.clk, .en, .x(q_t'(l11)), .y(q_t'(l20)), .z(pb), .sat(pb_s));
  lti4_mulq u_pc (.clk, .en, .x(q_t'(l21)), .y(q_t'(l32)), .z(pc), .sat(pc_s));
  lti4_mulq u_pe (.clk, .en, .x(q_t'(l22)), .y(q_t'(l31)), .z(pe), .sat(pe_s));
  lti4_mulq u_pf (.clk, .en, .x(q_t'(l11)), .y(q_t'(l22)), .z(pf), .sat(pf_s));
  lti4_mulq u_pg (.clk, .en, .x(q_t'(l10)), .y(q_t'(l22)), .z(pg), .sat(pg_s));

  lti4_mulq u_f30 (.clk, .en, .x(pf), .y(q_t'(ll[4].l30)), .z(f30), .sat(f30_s));
  lti4_mulq u_g31 (.clk, .en, .x(pg), .y(q_t'(ll[4].l31)), .z(g31), .sat(g31_s));
  lti4_mulq u_b32 (.clk, .en, .x(pb), .y(q_t'(ll[4].l32)), .z(b32), .sat(b32_s));
  lti4_mulq u_a32 (.clk, .en, .x(pa), .y(q_t'(ll[4].l32)), .z(a32), .sat(a32_s));

  always_comb begin
    n20_c = add_clamp(pa, -pb);
    n31_c = add_clamp(pc, -pe);
    s1_c  = add_clamp(g31, -f30);
    s2_c  = add_clamp(s1, b32_9);
    s3_c  = add_clamp(s2, -a32_10);
  end

  // The sum S is built one clamped add per stage, in the required order.
  always_ff @(posedge clk) begin
    if (en) begin
      nl[5]  <= '{n20: n20_c.v, n31: n31_c.v};
      n_sat  <= n20_c.sat | n31_c.sat;
      for (int k = 6; k <= TD + 4; k++) begin
        nl[k] <= nl[k-1];
      end
      s1     <= s1_c.v;
      s1_sat <= s1_c.sat;
      b32_9  <= b32;
      a32_9  <= a32;
      s2     <= s2_c.v;
      s2_sat <= s2_c.sat;
      a32_10 <= a32_9;
      sl[11] <= s3_c.v;
      s3_sat <= s3_c.sat;
      for (int k = 12; k <= TD; k++) begin
        sl[k] <= sl[k-1];
      end
    end
  end

  // ---------------- reciprocals of the diagonal, one quotient bit a stage ----------------
  always_comb begin
    dg[0] = l00;
    dg[1] = l11;
    dg[2] = l22;
    dg[3] = l33;
    for (int j = 0; j < 4; j++) begin
      dv_in[j].ua  = dg[j][DATA_WIDTH-1] ? DATA_WIDTH'(-dg[j]) : DATA_WIDTH'(dg[j]);
      dv_in[j].num = (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(dv_in[j].ua >> 1);
      dv_in[j].rem = '0;
      dv_in[j].q   = '0;
      dv_in[j].neg = dg[j][DATA_WIDTH-1];
      for (int k = 2; k <= NUM_W + 1; k++) begin
        dv_tr[j][k] = {dv[j][k-1].rem, dv[j][k-1].num[NUM_W-1]};
        dv_nx[j][k] = dv[j][k-1];
        dv_nx[j][k].num = dv[j][k-1].num << 1;
        if (dv_tr[j][k] >= {1'b0, dv[j][k-1].ua}) begin
          dv_nx[j][k].rem = DATA_WIDTH'(dv_tr[j][k] - {1'b0, dv[j][k-1].ua});
          dv_nx[j][k].q   = {dv[j][k-1].q[NUM_W-2:0], 1'b1};
        end else begin
          dv_nx[j][k].rem = dv_tr[j][k][DATA_WIDTH-1:0];
          dv_nx[j][k].q   = {dv[j][k-1].q[NUM_W-2:0], 1'b0};
        end
      end
      dq[j]     = CMP_W'(dv[j][NUM_W+1].q);
      dq_sat[j] = dq[j] > CMP_W'(Q_LIMIT);
      dq_mag[j] = dq_sat[j] ? Q_LIMIT : mag_t'(dv[j][NUM_W+1].q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        dv[j][1] <= dv_in[j];
        for (int k = 2; k <= NUM_W + 1; k++) begin
          dv[j][k] <= dv_nx[j][k];
        end
        dl[TD][j] <= dv[j][NUM_W+1].neg ? -q_t'({1'b0, dq_mag[j]}) : q_t'({1'b0, dq_mag[j]});
        d_sat[j]  <= dq_sat[j];
        for (int k = TD + 1; k <= TE; k++) begin
          dl[k][j] <= dl[k-1][j];
        end
      end
    end
  end

  // ---------------- chains through the reciprocals, all ending together ----------------
  lti4_mulq u_c6a (.clk, .en, .x(sl[TD]), .y(dl[TD][0]), .z(c6a), .sat(c6a_s));

  lti4_mulq u_c6b (.clk, .en, .x(c6a), .y(dl[TD+4][1]), .z(c6b), .sat(c6b_s));
  lti4_mulq u_c3a (.clk, .en, .x(nl[TD+4].n20), .y(dl[TD+4][0]), .z(c3a), .sat(c3a_s));
  lti4_mulq u_c7a (.clk, .en, .x(nl[TD+4].n31), .y(dl[TD+4][1]), .z(c7a), .sat(c7a_s));

  lti4_mulq u_c6c (.clk, .en, .x(c6b), .y(dl[TD+8][2]), .z(c6c), .sat(c6c_s));
  lti4_mulq u_c3b (.clk, .en, .x(c3a), .y(dl[TD+8][1]), .z(c3b), .sat(c3b_s));
  lti4_mulq u_c7b (.clk, .en, .x(c7a), .y(dl[TD+8][2]), .z(c7b), .sat(c7b_s));
  lti4_mulq u_c1a (.clk, .en, .x(q_t'(ll[TD+8].l10)), .y(dl[TD+8][0]), .z(c1a), .sat(c1a_s));
  lti4_mulq u_c4a (.clk, .en, .x(q_t'(ll[TD+8].l21)), .y(dl[TD+8][1]), .z(c4a), .sat(c4a_s));
  lti4_mulq u_c8a (.clk, .en, .x(q_t'(ll[TD+8].l32)), .y(dl[TD+8][2]), .z(c8a), .sat(c8a_s));

  lti4_mulq u_c6d (.clk, .en, .x(c6c), .y(dl[TD+12][3]), .z(c6d), .sat(c6d_s));
  lti4_mulq u_c3c (.clk, .en, .x(c3b), .y(dl[TD+12][2]), .z(c3c), .sat(c3c_s));
  lti4_mulq u_c7c (.clk, .en, .x(c7b), .y(dl[TD+12][3]), .z(c7c), .sat(c7c_s));
  lti4_mulq u_c1b (.clk, .en, .x(c1a), .y(dl[TD+12][1]), .z(c1b), .sat(c1b_s));
  lti4_mulq u_c4b (.clk, .en, .x(c4a), .y(dl[TD+12][2]), .z(c4b), .sat(c4b_s));
  lti4_mulq u_c8b (.clk, .en, .x(c8a), .y(dl[TD+12][3]), .z(c8b), .sat(c8b_s));

  // Saturation events, placed at the stage where each flag register sits.
  always_comb begin
    evt         = '0;
    evt[4]      = pa_s | pb_s | pc_s | pe_s | pf_s | pg_s;
    evt[5]      = n_sat;
    evt[8]      = f30_s | g31_s | b32_s | a32_s;
    evt[9]      = s1_sat;
    evt[10]     = s2_sat;
    evt[11]     = s3_sat;
    evt[TD]     = |d_sat;
    evt[TD+4]   = c6a_s;
    evt[TD+8]   = c6b_s | c3a_s | c7a_s;
    evt[TD+12]  = c6c_s | c3b_s | c7b_s | c1a_s | c4a_s | c8a_s;
    evt[TE]     = c6d_s | c3c_s | c7c_s | c1b_s | c4b_s | c8b_s;
  end

  // ---------------- output stage ----------------
  always_comb begin
    rv[0] = dl[TE][0];
    rv[1] = -c1b;
    rv[2] = dl[TE][1];
    rv[3] = c3c;
    rv[4] = -c4b;
    rv[5] = dl[TE][2];
    rv[6] = c6d;
    rv[7] = c7c;
    rv[8] = -c8b;
    rv[9] = dl[TE][3];
    any_sat = fl[TE].sat | evt[TE];
    for (int i = 0; i < 10; i++) begin
      os[i]   = sat_out(rv[i]);
      any_sat = any_sat | os[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fl[TE].zero) begin
        for (int i = 0; i < 10; i++) begin
          ov[i] <= '0;
        end
        ov[0] <= ONE_VAL;
        ov[2] <= ONE_VAL;
        ov[5] <= ONE_VAL;
        ov[9] <= ONE_VAL;
        st    <= ST_ZERO;
      end else begin
        for (int i = 0; i < 10; i++) begin
          ov[i] <= os[i].v;
        end
        st <= any_sat ? ST_SAT : ST_OK;
      end
    end
  end

  assign out_valid = vld[TO];
  assign inv_r0c0  = ov[0];
  assign inv_r1c0  = ov[1];
  assign inv_r1c1  = ov[2];
  assign inv_r2c0  = ov[3];
  assign inv_r2c1  = ov[4];
  assign inv_r2c2  = ov[5];
  assign inv_r3c0  = ov[6];
  assign inv_r3c1  = ov[7];
  assign inv_r3c2  = ov[8];
  assign inv_r3c3  = ov[9];
  assign status    = st;

`ifndef SYNTHESIS
  a_zero_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ZERO |-> inv_r0c0 == ONE_VAL && inv_r3c3 == ONE_VAL
                                       && inv_r1c0 == '0 && inv_r3c0 == '0)
    else $error("zero-diagonal result is not the identity");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(en) |-> vld == $past(vld))
    else $error("pipeline moved while the output was stalled");

  a_capture: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(in_valid && !in_stall) |-> vld[0])
    else $error("input transfer was not marked valid in the first stage");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_ZERO || status == ST_SAT))
    else $error("undefined status code on a valid result");
`endif

endmodule

// ===== design/lti4_mulq.sv =====
// ----------------------------------------------------------------------------
// lti4_mulq
// Four-stage fixed-point multiplier: magnitude, partial products, rounded
// sum, then saturation to the internal range and sign restore.
// ----------------------------------------------------------------------------
module lti4_mulq (
  input  logic          clk,
  input  logic          en,
  input  lti4_pkg::q_t  x,
  input  lti4_pkg::q_t  y,
  output lti4_pkg::q_t  z,
  output logic          sat
);
  import lti4_pkg::*;

  mag_t ux, uy;
  logic neg1, neg2, neg3;
  logic [2*HALF_W-1:0]    p_ll;
  logic [HALF_W+HI_W-1:0] p_lh, p_hl;
  logic [2*HI_W-1:0]      p_hh;
  logic [PROD_W-1:0]      acc;
  logic [PROD_W-FRAC_BITS-1:0] rnd;
  logic rsat;
  mag_t rmag;

  always_comb begin
    rnd  = acc[PROD_W-1:FRAC_BITS];
    rsat = rnd > (PROD_W-FRAC_BITS)'(Q_LIMIT);
    rmag = rsat ? Q_LIMIT : rnd[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux   <= x[IW-1] ? mag_t'(-x) : mag_t'(x);
      uy   <= y[IW-1] ? mag_t'(-y) : mag_t'(y);
      neg1 <= x[IW-1] ^ y[IW-1];

      p_ll <= ux[HALF_W-1:0] * uy[HALF_W-1:0];
      p_lh <= ux[HALF_W-1:0] * uy[MAG_W-1:HALF_W];
      p_hl <= ux[MAG_W-1:HALF_W] * uy[HALF_W-1:0];
      p_hh <= ux[MAG_W-1:HALF_W] * uy[MAG_W-1:HALF_W];
      neg2 <= neg1;

      // Rounding adds half an LSB of the result before the shift.
      acc  <= (PROD_W'(p_hh) << (2 * HALF_W)) + (PROD_W'(p_lh) << HALF_W)
            + (PROD_W'(p_hl) << HALF_W) + PROD_W'(p_ll)
            + (PROD_W'(1) << (FRAC_BITS - 1));
      neg3 <= neg2;

      z    <= neg3 ? -q_t'({1'b0, rmag}) : q_t'({1'b0, rmag});
      sat  <= rsat;
    end
  end

endmodule
